@@ rtl/core/epe_pkg.sv @@
// Shared constants, opcodes and types for the even polynomial evaluator.
package epe_pkg;

  localparam int MAX_DEGREE_DEF = 16;
  localparam int WORD_BITS_DEF  = 48;

  localparam int COEFF_BITS = 48;
  localparam int R2_BITS    = 47;
  localparam int OP_BITS    = 2;
  localparam int IDX_BITS   = 5;
  localparam int DEG_BITS   = 5;
  localparam int INT_BITS   = 16;

  localparam logic [DEG_BITS-1:0] DEGREE_RESET = 5'd2;
  localparam logic [DEG_BITS-1:0] DEGREE_MIN   = 5'd2;

  // r2 is consumed by the multiplier one digit per cycle, top digit first
  localparam int DIGIT_BITS   = 16;
  localparam int R2_DIGITS    = (R2_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int R2_PAD_BITS  = DIGIT_BITS * R2_DIGITS;
  localparam int DIG_CNT_BITS = $clog2(R2_DIGITS);

  localparam logic [OP_BITS-1:0] OP_LOAD_VALUE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD_DERIV = 2'd1;
  localparam logic [OP_BITS-1:0] OP_EVAL       = 2'd2;

  typedef struct packed {
    logic done;
    logic ovf;
  } epe_step_stat_t;

endpackage

@@ rtl/core/epe_cell.sv @@
// One coefficient cell of the rotating chain: holds one a entry and one b entry.
module epe_cell
  import epe_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic                        wr_a,
  input  logic                        wr_b,
  input  logic signed [WORD_BITS-1:0] wr_data,
  input  logic signed [WORD_BITS-1:0] prev_a,
  input  logic signed [WORD_BITS-1:0] prev_b,
  output logic signed [WORD_BITS-1:0] a_q,
  output logic signed [WORD_BITS-1:0] b_q
);

  logic signed [WORD_BITS-1:0] a_r;
  logic signed [WORD_BITS-1:0] b_r;

  // rotation and loads never overlap; rotation wins if they did
  always_ff @(posedge clk) begin
    priority if (shift_en) begin
      a_r <= prev_a;
      b_r <= prev_b;
    end else begin
      if (wr_a) begin
        a_r <= wr_data;
      end
      if (wr_b) begin
        b_r <= wr_data;
      end
    end
  end

  assign a_q = a_r;
  assign b_q = b_r;

endmodule

@@ rtl/core/epe_step_unit.sv @@
// Horner step: y = sat(sat_round(x * r2) + coeff), digit-serial multiplier.
module epe_step_unit
  import epe_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [WORD_BITS-1:0] x,
  input  logic signed [WORD_BITS-1:0] coeff,
  input  logic        [R2_BITS-1:0]   r2,
  output logic signed [WORD_BITS-1:0] y,
  output epe_step_stat_t              stat
);

  localparam int FRAC_BITS = WORD_BITS - INT_BITS;
  localparam int PROD_W    = WORD_BITS + R2_BITS;
  localparam int Q_W       = PROD_W - FRAC_BITS;
  localparam int CMP_W     = PROD_W + 1;
  localparam int PP_W      = WORD_BITS + DIGIT_BITS;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_RND  = 2'd2;
  localparam logic [1:0] P_ADD  = 2'd3;

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic [1:0]                  phase_r;
  logic [DIG_CNT_BITS-1:0]     cnt_r;
  logic                        neg_r;
  logic [WORD_BITS-1:0]        mag_r;
  logic signed [WORD_BITS-1:0] coeff_r;
  logic [R2_PAD_BITS-1:0]      dig_r;
  logic [PROD_W-1:0]           prod_r;
  logic signed [WORD_BITS-1:0] mres_r;
  logic                        movf_r;
  logic signed [WORD_BITS-1:0] y_r;
  epe_step_stat_t              stat_r;

  logic [DIGIT_BITS-1:0]       digit;
  logic [PP_W-1:0]             pp;
  logic [PROD_W-1:0]           prod_acc;
  logic [PROD_W-1:0]           rnd_sum;
  logic [Q_W-1:0]              q;
  logic [CMP_W-1:0]            q_ext;
  logic [CMP_W-1:0]            lim;
  logic                        mul_sat;
  logic [WORD_BITS-1:0]        q_low;
  logic [WORD_BITS-1:0]        mul_val;
  logic [WORD_BITS-1:0]        mul_res;
  logic [WORD_BITS:0]          sum;
  logic                        add_ovf;
  logic [WORD_BITS-1:0]        add_res;

  assign digit    = dig_r[R2_PAD_BITS-1 -: DIGIT_BITS];
  assign pp       = PP_W'(mag_r) * PP_W'(digit);
  assign prod_acc = (prod_r << DIGIT_BITS) + PROD_W'(pp);

  // round to nearest, ties away from zero, on the magnitude
  assign rnd_sum = prod_r + PROD_W'({1'b1, {(FRAC_BITS-1){1'b0}}});
  assign q       = rnd_sum[PROD_W-1:FRAC_BITS];
  assign q_ext   = CMP_W'(q);
  assign lim     = CMP_W'(WMAX) + CMP_W'(neg_r);
  assign mul_sat = q_ext > lim;
  assign q_low   = q_ext[WORD_BITS-1:0];
  assign mul_val = neg_r ? (~q_low + 1'b1) : q_low;
  assign mul_res = mul_sat ? (neg_r ? WMIN : WMAX) : mul_val;

  assign sum     = {mres_r[WORD_BITS-1], mres_r} + {coeff_r[WORD_BITS-1], coeff_r};
  assign add_ovf = sum[WORD_BITS] != sum[WORD_BITS-1];
  assign add_res = add_ovf ? (sum[WORD_BITS] ? WMIN : WMAX) : sum[WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      stat_r  <= '0;
    end else begin
      // pulse done for one cycle as the add phase retires
      stat_r.done <= (phase_r == P_ADD);
      unique case (phase_r)
        P_IDLE: begin
          if (start) begin
            neg_r   <= x[WORD_BITS-1];
            mag_r   <= x[WORD_BITS-1] ? (~x + 1'b1) : x;
            coeff_r <= coeff;
            dig_r   <= R2_PAD_BITS'(r2);
            prod_r  <= '0;
            cnt_r   <= '0;
            phase_r <= P_MUL;
          end
        end
        P_MUL: begin
          prod_r <= prod_acc;
          dig_r  <= dig_r << DIGIT_BITS;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == DIG_CNT_BITS'(R2_DIGITS - 1)) begin
            phase_r <= P_RND;
          end
        end
        P_RND: begin
          mres_r  <= mul_res;
          movf_r  <= mul_sat;
          phase_r <= P_ADD;
        end
        P_ADD: begin
          y_r         <= add_res;
          stat_r.ovf  <= movf_r | add_ovf;
          phase_r     <= P_IDLE;
        end
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  assign y    = y_r;
  assign stat = stat_r;

endmodule

@@ rtl/core/even_polynomial_eval_with_derivative.sv @@
// Top level: coefficient chain, Horner sequencer and result register.
//
// Evaluates f0 = sum a[n]*r2^n and f1 = sum b[n]*r2^n by Horner's rule in
// signed fixed point (WORD_BITS bits, WORD_BITS-16 fraction bits), rounding
// each product to nearest (ties away from zero) and saturating every product
// and sum; out_overflow reports that any of them saturated. A request with
// op OP_LOAD_VALUE writes a[coeff_index], OP_LOAD_DERIV writes b[coeff_index]
// (out-of-range indexes and the unused opcode are dropped) and gives no
// result. OP_EVAL gives one result. Coefficients live in a circular chain
// of MAX_DEGREE+1 cells (cell k holds a[k] and b[k-1]) that rotates toward
// the head cell; an evaluation with N = clamp(cfg degree, 2, MAX_DEGREE)
// first rotates the chain MAX_DEGREE-N places to bring a[N] to the head,
// then runs 2N-1 multiply-adds on one shared step unit, one full chain turn
// in all, so the chain is back in place when the result is posted. Each
// multiply-add steps the 16-bit digit-serial multiplier across the 47-bit
// r2, then rounds, adds and hands off. An evaluation occupies the block
// until its result has been moved into the output register, and no new
// request of any kind is taken before then. The result sits in an
// output register, so a finished result may wait on out_ready while loads
// and a new evaluation proceed. Coefficients read by an evaluation must have
// been loaded first; write cfg_wr_data only while the block is idle.
module even_polynomial_eval_with_derivative
  import epe_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic        [DEG_BITS-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [OP_BITS-1:0]    in_op,
  input  logic        [IDX_BITS-1:0]   in_coeff_index,
  input  logic signed [COEFF_BITS-1:0] in_coeff_value,
  input  logic        [R2_BITS-1:0]    in_radius_squared,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_BITS-1:0]  out_value,
  output logic signed [WORD_BITS-1:0]  out_radial_derivative,
  output logic                         out_overflow
);

  localparam int DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int EXT_W = ((WORD_BITS > COEFF_BITS) ? WORD_BITS : COEFF_BITS) + 1;
  localparam int HEAD  = MAX_DEGREE;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SKIP   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                  state_r;
  logic [DEG_BITS-1:0]         degree_r;
  logic [DEG_W-1:0]            skip_r;
  logic [DEG_W-1:0]            steps_r;
  logic                        sel_r;
  logic signed [WORD_BITS-1:0] acc0_r;
  logic signed [WORD_BITS-1:0] acc1_r;
  logic [R2_BITS-1:0]          r2_r;
  logic                        ovf_r;
  logic                        out_valid_r;
  logic signed [WORD_BITS-1:0] out_value_r;
  logic signed [WORD_BITS-1:0] out_deriv_r;
  logic                        out_ovf_r;

  logic                        in_fire;
  logic                        load_fire;
  logic [DEG_W-1:0]            n_clamp;
  logic signed [EXT_W-1:0]     coeff_ext;
  logic signed [EXT_W-1:0]     cmax;
  logic signed [EXT_W-1:0]     cmin;
  logic signed [WORD_BITS-1:0] wr_data;
  logic                        shift_en;
  logic                        result_free;

  logic signed [WORD_BITS-1:0] cell_a [MAX_DEGREE+1];
  logic signed [WORD_BITS-1:0] cell_b [MAX_DEGREE+1];

  logic                        step_start;
  logic signed [WORD_BITS-1:0] step_x;
  logic signed [WORD_BITS-1:0] step_coeff;
  logic signed [WORD_BITS-1:0] step_y;
  epe_step_stat_t              step_stat;

  assign in_ready    = state_r == S_IDLE;
  assign in_fire     = in_valid && in_ready;
  assign load_fire   = in_fire && (in_op == OP_LOAD_VALUE || in_op == OP_LOAD_DERIV);
  assign result_free = !out_valid_r || out_ready;

  // clamp the configured degree into [2, MAX_DEGREE]
  always_comb begin
    if (degree_r < DEGREE_MIN) begin
      n_clamp = DEG_W'(DEGREE_MIN);
    end else if (32'(degree_r) > MAX_DEGREE) begin
      n_clamp = DEG_W'(MAX_DEGREE);
    end else begin
      n_clamp = DEG_W'(degree_r);
    end
  end

  // saturate an incoming coefficient into the word range
  assign coeff_ext = EXT_W'(in_coeff_value);
  assign cmax      = EXT_W'({1'b0, {(WORD_BITS-1){1'b1}}});
  assign cmin      = ~cmax;
  always_comb begin
    if (coeff_ext > cmax) begin
      wr_data = cmax[WORD_BITS-1:0];
    end else if (coeff_ext < cmin) begin
      wr_data = cmin[WORD_BITS-1:0];
    end else begin
      wr_data = coeff_ext[WORD_BITS-1:0];
    end
  end

  // advance the chain once per skipped entry and once per consumed entry
  assign shift_en = (state_r == S_SKIP) ||
                    (state_r == S_WAIT && step_stat.done && (sel_r || steps_r == DEG_W'(1)));

  for (genvar i = 0; i <= MAX_DEGREE; i++) begin : g_cell
    localparam int PREV = (i == 0) ? MAX_DEGREE : i - 1;
    logic wr_a;
    logic wr_b;

    assign wr_a = load_fire && in_op == OP_LOAD_VALUE && 32'(in_coeff_index) == i;
    assign wr_b = load_fire && in_op == OP_LOAD_DERIV && i >= 1 &&
                  32'(in_coeff_index) == i - 1;

    epe_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .wr_a     (wr_a),
      .wr_b     (wr_b),
      .wr_data  (wr_data),
      .prev_a   (cell_a[PREV]),
      .prev_b   (cell_b[PREV]),
      .a_q      (cell_a[i]),
      .b_q      (cell_b[i])
    );
  end

  assign step_start = state_r == S_LAUNCH;
  assign step_x     = sel_r ? acc1_r : acc0_r;
  assign step_coeff = sel_r ? cell_b[HEAD] : cell_a[HEAD];

  epe_step_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_start),
    .x     (step_x),
    .coeff (step_coeff),
    .r2    (r2_r),
    .y     (step_y),
    .stat  (step_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEGREE_RESET;
    end else if (cfg_wr_en) begin
      degree_r <= cfg_wr_data;
    end
  end

  // sequencer: skip down to a[N], then alternate f0 and f1 steps per entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_op == OP_EVAL) begin
            r2_r    <= in_radius_squared;
            skip_r  <= DEG_W'(MAX_DEGREE) - n_clamp;
            steps_r <= n_clamp;
            ovf_r   <= 1'b0;
            sel_r   <= 1'b0;
            state_r <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip_r == '0) begin
            // top coefficients seed both sums
            acc0_r  <= cell_a[HEAD];
            acc1_r  <= cell_b[HEAD];
            state_r <= S_LAUNCH;
          end else begin
            skip_r <= skip_r - 1'b1;
          end
        end
        S_LAUNCH: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (step_stat.done) begin
            if (sel_r) begin
              acc1_r <= step_y;
            end else begin
              acc0_r <= step_y;
            end
            ovf_r <= ovf_r | step_stat.ovf;
            priority if (!sel_r && steps_r != DEG_W'(1)) begin
              sel_r   <= 1'b1;
              state_r <= S_LAUNCH;
            end else begin
              // f1 has one step fewer: drop it on the last entry
              sel_r   <= 1'b0;
              steps_r <= steps_r - 1'b1;
              state_r <= (steps_r == DEG_W'(1)) ? S_DONE : S_LAUNCH;
            end
          end
        end
        S_DONE: begin
          if (result_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register: hold until taken, reload when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      priority if (state_r == S_DONE && result_free) begin
        out_valid_r <= 1'b1;
        out_value_r <= acc0_r;
        out_deriv_r <= acc1_r;
        out_ovf_r   <= ovf_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_value             = out_value_r;
  assign out_radial_derivative = out_deriv_r;
  assign out_overflow          = out_ovf_r;

endmodule

@@ tb/even_polynomial_eval_with_derivative_tb.sv @@
// Self-checking testbench for the even polynomial evaluator with radial derivative.
module even_polynomial_eval_with_derivative_tb;
  import epe_pkg::*;

  localparam int MAXD = MAX_DEGREE_DEF;
  localparam int WB   = WORD_BITS_DEF;
  localparam int FRAC = WB - INT_BITS;
  // Wide enough for a full 48 x 47 bit product plus the rounding half.
  localparam int PW   = WB + R2_BITS + 1;

  localparam longint WORD_MAX = (64'sd1 <<< (WB - 1)) - 64'sd1;
  localparam longint WORD_MIN = -WORD_MAX - 64'sd1;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [COEFF_BITS-1:0] COEFF_MAX  = {1'b0, {(COEFF_BITS-1){1'b1}}};
  localparam logic signed [COEFF_BITS-1:0] COEFF_MIN  = {1'b1, {(COEFF_BITS-1){1'b0}}};
  localparam logic signed [COEFF_BITS-1:0] COEFF_ONE  = COEFF_BITS'(1) <<< FRAC;
  localparam logic signed [COEFF_BITS-1:0] COEFF_LSB  = COEFF_BITS'(1);
  localparam logic [R2_BITS-1:0]           R2_ONE     = R2_BITS'(1) << FRAC;
  localparam logic [R2_BITS-1:0]           R2_MAX     = {R2_BITS{1'b1}};

  // Settle time after the queue drains; longer than a full-degree evaluation.
  localparam int SETTLE_CYCLES = 240;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic signed [WB-1:0] value;
    logic signed [WB-1:0] slope;
    logic                 ovf;
  } kernel_sample_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic        [DEG_BITS-1:0]   cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic        [OP_BITS-1:0]    in_op = '0;
  logic        [IDX_BITS-1:0]   in_coeff_index = '0;
  logic signed [COEFF_BITS-1:0] in_coeff_value = '0;
  logic        [R2_BITS-1:0]    in_radius_squared = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [WB-1:0]         out_value;
  logic signed [WB-1:0]         out_radial_derivative;
  logic                         out_overflow;

  // Shadow copy of the coefficient tables and the degree register.
  longint                value_tab [0:MAXD];
  longint                deriv_tab [0:MAXD-1];
  logic [DEG_BITS-1:0]   degree_shadow = DEGREE_RESET;

  kernel_sample_t queued_kernels [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_left          = 0;
  int cycle_count        = 0;
  int error_count        = 0;

  even_polynomial_eval_with_derivative dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_coeff_index        (in_coeff_index),
    .in_coeff_value        (in_coeff_value),
    .in_radius_squared     (in_radius_squared),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_value             (out_value),
    .out_radial_derivative (out_radial_derivative),
    .out_overflow          (out_overflow)
  );

  always #2 clk = ~clk;

  // Kill a hung run; the slowest legal run stays far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: honor a long hold-off first, otherwise stall at random.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    // Keep the log bounded on a badly broken block; every failure still counts.
    if (error_count < 100)
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Compare every accepted result against the oldest pending evaluation.
  always @(posedge clk) begin : check_results
    kernel_sample_t want;
    if (rst_n && out_valid && out_ready) begin
      if (queued_kernels.size() == 0) begin
        report_mismatch("result with no evaluation pending", longint'(out_value), 0);
      end else begin
        want = queued_kernels.pop_front();
        if (out_value !== want.value)
          report_mismatch("value", longint'(out_value), longint'(want.value));
        if (out_radial_derivative !== want.slope)
          report_mismatch("radial_derivative", longint'(out_radial_derivative),
                          longint'(want.slope));
        if (out_overflow !== want.ovf)
          report_mismatch("overflow", longint'(out_overflow), longint'(want.ovf));
      end
    end
  end

  // Horner sum over one shadow table from entry top down to entry 0. Each step
  // rounds the product to nearest with ties away from zero, then saturates the
  // product and the sum; sat flags any saturation.
  function automatic longint horner_sum(input bit use_value, input int top,
                                        input logic [R2_BITS-1:0] r2, output bit sat);
    longint       acc;
    longint       sum;
    logic [WB-1:0] mag;
    logic [PW-1:0] prod;
    bit           neg;
    sat = 1'b0;
    acc = use_value ? value_tab[top] : deriv_tab[top];
    for (int k = top - 1; k >= 0; k--) begin
      neg  = acc < 0;
      mag  = neg ? WB'(-acc) : WB'(acc);
      prod = PW'(mag) * PW'(r2) + (PW'(1) << (FRAC - 1));
      prod = prod >> FRAC;
      if (prod > PW'(neg ? WORD_MAX + 64'sd1 : WORD_MAX)) begin
        sat = 1'b1;
        acc = neg ? WORD_MIN : WORD_MAX;
      end else begin
        acc = neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
      end
      sum = acc + (use_value ? value_tab[k] : deriv_tab[k]);
      if (sum > WORD_MAX) begin
        sum = WORD_MAX;
        sat = 1'b1;
      end else if (sum < WORD_MIN) begin
        sum = WORD_MIN;
        sat = 1'b1;
      end
      acc = sum;
    end
    return acc;
  endfunction

  // Coefficients of every scale, both signs, and the two word extremes.
  function automatic logic signed [COEFF_BITS-1:0] rand_coeff();
    logic signed [COEFF_BITS-1:0] v;
    v = COEFF_BITS'({$urandom, $urandom});
    case ($urandom_range(7))
      0: return v;
      1: return $urandom_range(1) ? COEFF_MAX : COEFF_MIN;
      default: return v >>> $urandom_range(12, COEFF_BITS - 1);
    endcase
  endfunction

  // Mostly r2 below 2.0 so long chains stay in range; the rest at any scale.
  function automatic logic [R2_BITS-1:0] rand_r2();
    logic [R2_BITS-1:0] v;
    v = R2_BITS'({$urandom, $urandom});
    case ($urandom_range(7))
      0: return v;
      1: return v >> $urandom_range(R2_BITS - 1);
      2: return v >> (R2_BITS - FRAC - 1);
      default: return v >> (R2_BITS - FRAC);
    endcase
  endfunction

  // Offer one request, hold it until accepted, then update the shadow state
  // and queue the evaluation result it will produce.
  task automatic send_request(input logic [OP_BITS-1:0] op,
                              input logic [IDX_BITS-1:0] idx,
                              input logic signed [COEFF_BITS-1:0] coeff,
                              input logic [R2_BITS-1:0] r2);
    int             gap;
    int             top;
    bit             sat_f0;
    bit             sat_f1;
    kernel_sample_t want;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= op;
    in_coeff_index    <= idx;
    in_coeff_value    <= coeff;
    in_radius_squared <= r2;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (op)
      OP_LOAD_VALUE: if (idx <= MAXD) value_tab[idx] = longint'(coeff);
      OP_LOAD_DERIV: if (idx < MAXD) deriv_tab[idx] = longint'(coeff);
      OP_EVAL: begin
        // Degree outside 2..MAX_DEGREE is clamped by the block.
        top = int'(degree_shadow);
        if (top < int'(DEGREE_MIN)) top = int'(DEGREE_MIN);
        if (top > MAXD) top = MAXD;
        want.value = WB'(horner_sum(1'b1, top, r2, sat_f0));
        want.slope = WB'(horner_sum(1'b0, top - 1, r2, sat_f1));
        want.ovf   = sat_f0 | sat_f1;
        queued_kernels.push_back(want);
      end
      default: ;
    endcase
  endtask

  // Drop valid, drain every pending result, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (queued_kernels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_degree(input logic [DEG_BITS-1:0] deg);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= deg;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    degree_shadow = deg;
  endtask

  // Reset degree: hand-picked quadratic, r2 extremes, dropped requests,
  // rounding ties and saturation in both directions.
  task automatic test_directed_reset_degree();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    // f0 = 1 - 2 r2 + 0.5 r2^2, f1 = 3 - r2
    send_request(OP_LOAD_VALUE, IDX_BITS'(0), COEFF_ONE, '0);
    send_request(OP_LOAD_VALUE, IDX_BITS'(1), -(COEFF_ONE <<< 1), '0);
    send_request(OP_LOAD_VALUE, IDX_BITS'(2), COEFF_ONE >>> 1, '0);
    send_request(OP_LOAD_DERIV, IDX_BITS'(0), COEFF_ONE * 3, '0);
    send_request(OP_LOAD_DERIV, IDX_BITS'(1), -COEFF_ONE, '0);
    // r2 of zero returns the constant terms alone
    send_request(OP_EVAL, '0, '0, '0);
    send_request(OP_EVAL, '0, '0, R2_ONE);
    send_request(OP_EVAL, '1, COEFF_MIN, R2_MAX);
    // Unused opcode and out-of-range indexes must leave the tables alone.
    send_request(OP_UNUSED, '1, COEFF_MAX, R2_MAX);
    send_request(OP_LOAD_VALUE, IDX_BITS'(MAXD + 1), COEFF_MAX, '0);
    send_request(OP_LOAD_DERIV, IDX_BITS'(MAXD), COEFF_MIN, '0);
    send_request(OP_LOAD_VALUE, '1, {COEFF_BITS{1'b1}}, '0);
    send_request(OP_LOAD_DERIV, '1, COEFF_MAX, '0);
    send_request(OP_EVAL, '0, '0, R2_ONE * 3);
    // Half-LSB products: -1 LSB times 0.5 rounds away from zero
    send_request(OP_LOAD_VALUE, IDX_BITS'(2), -COEFF_LSB, '0);
    send_request(OP_LOAD_DERIV, IDX_BITS'(1), COEFF_LSB, '0);
    send_request(OP_EVAL, '0, '0, R2_ONE >> 1);
    send_request(OP_EVAL, '0, '0, R2_BITS'(1));
    // Sums pinned at the negative and the positive rail
    send_request(OP_LOAD_VALUE, IDX_BITS'(2), COEFF_MIN, '0);
    send_request(OP_LOAD_VALUE, IDX_BITS'(1), COEFF_MIN, '0);
    send_request(OP_LOAD_DERIV, IDX_BITS'(1), COEFF_MAX, '0);
    send_request(OP_LOAD_DERIV, IDX_BITS'(0), COEFF_MAX, '0);
    send_request(OP_EVAL, '0, '0, R2_ONE);
    send_request(OP_EVAL, '0, '0, R2_MAX);
  endtask

  // Fill both tables, then run clamped and extreme degree settings.
  task automatic test_degree_limits();
    logic [DEG_BITS-1:0] settings [5] = '{5'd1, 5'd17, 5'd0, 5'd31, 5'd16};
    for (int i = 0; i <= MAXD; i++)
      send_request(OP_LOAD_VALUE, IDX_BITS'(i), rand_coeff(), rand_r2());
    for (int i = 0; i < MAXD; i++)
      send_request(OP_LOAD_DERIV, IDX_BITS'(i), rand_coeff(), rand_r2());
    foreach (settings[i]) begin
      write_degree(settings[i]);
      send_request(OP_EVAL, IDX_BITS'($urandom), rand_coeff(), R2_ONE);
      send_request(OP_EVAL, IDX_BITS'($urandom), rand_coeff(), rand_r2());
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so the
  // output register fills and the input side backs up.
  task automatic test_backpressure();
    write_degree(DEGREE_MIN);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_left <= 300;
    for (int i = 0; i < 14; i++) begin
      if (i % 3 == 2)
        send_request(OP_LOAD_VALUE, IDX_BITS'($urandom_range(2)), rand_coeff(), rand_r2());
      else
        send_request(OP_EVAL, IDX_BITS'($urandom), rand_coeff(), rand_r2());
    end
  endtask

  // Random mix at one degree and one idle profile; dropped requests count
  // toward the total like any other.
  task automatic test_random_traffic(input int deg, input int idle_pct,
                                     input int stall_pct, input int requests);
    int                  sent;
    int                  pick;
    logic [OP_BITS-1:0]  op;
    logic [IDX_BITS-1:0] idx;
    write_degree(DEG_BITS'(deg));
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < requests) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        op  = OP_EVAL;
        idx = IDX_BITS'($urandom);
      end else if (pick < 90) begin
        op  = $urandom_range(1) ? OP_LOAD_VALUE : OP_LOAD_DERIV;
        idx = (op == OP_LOAD_VALUE) ? IDX_BITS'($urandom_range(MAXD))
                                    : IDX_BITS'($urandom_range(MAXD - 1));
      end else if (pick < 95) begin
        op  = OP_UNUSED;
        idx = IDX_BITS'($urandom);
      end else begin
        op  = $urandom_range(1) ? OP_LOAD_VALUE : OP_LOAD_DERIV;
        idx = (op == OP_LOAD_VALUE) ? IDX_BITS'($urandom_range(MAXD + 1, 31))
                                    : IDX_BITS'($urandom_range(MAXD, 31));
      end
      send_request(op, idx, rand_coeff(), rand_r2());
      sent++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_reset_degree();
    test_degree_limits();
    test_backpressure();

    // Sweep the idle profiles over small, full and clamped degrees.
    test_random_traffic(2, 0, 0, 180);
    test_random_traffic(16, 46, 0, 180);
    test_random_traffic($urandom_range(3, 15), 0, 46, 180);
    test_random_traffic(0, 17, 17, 180);
    test_random_traffic(31, 0, 0, 150);
    test_random_traffic($urandom_range(0, 31), 17, 17, 180);

    wait_idle();
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
